>>> design/dtlv_pkg.sv
// ----------------------------------------------------------------------------
// DER TLV header parser package
// Shared types and constants for the DER TLV header parser: result kinds,
// error codes, parser phases and the result record passed front to back.
// ----------------------------------------------------------------------------
package dtlv_pkg;

	// Longest long-form length field accepted, in bytes.
	localparam int unsigned MAX_LENGTH_BYTES = 4;

	// Identifier and length byte masks.
	localparam logic [7:0] ID_CONSTRUCTED = 8'h20;
	localparam logic [4:0] ID_HIGH_TAG    = 5'h1f;
	localparam logic [7:0] LEN_LONG_FORM  = 8'h80;
	localparam logic [6:0] LEN_COUNT_MASK = 7'h7f;

	typedef enum logic [1:0] {
		KIND_DESC  = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_HIGH_TAG  = 3'd1,
		ERR_TRUNCATED = 3'd2,
		ERR_BAD_COUNT = 3'd3,
		ERR_LEAD_ZERO = 3'd4,
		ERR_NON_MIN   = 3'd5,
		ERR_OVERFLOW  = 3'd6,
		ERR_PAST_END  = 3'd7
	} err_code_t;

	typedef enum logic [4:0] {
		PH_IDENT     = 5'b00001,
		PH_LEN_FIRST = 5'b00010,
		PH_LEN_LONG  = 5'b00100,
		PH_CONTENT   = 5'b01000,
		PH_ERROR     = 5'b10000
	} phase_t;

	// Compact result record. byte_val carries the identifier byte for a
	// descriptor and the content byte for a data result.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_val;
		logic [31:0] length;
		logic [2:0]  hdr_len;
		logic [31:0] start;
		logic        last;
		err_code_t   code;
	} rec_t;

	localparam int unsigned TDATA_W = 88;

endpackage

>>> design/der_tlv_header_parser.sv
// ----------------------------------------------------------------------------
// DER TLV header parser
// Walks the sibling elements of a DER buffer one byte per beat and reports
// element descriptors, content bytes and the first encoding error.
// ----------------------------------------------------------------------------
// Usage:
// Set the buffer size through cfg_wr_en/cfg_wr_data while the block is idle,
// then stream the buffer bytes, in order, on the s_t* slave channel.
// Every byte beat yields at most one result beat on the m_t* master channel:
// an element descriptor when a header completes, one beat per content byte
// (m_tlast on the last one, or on the descriptor of an empty element), or
// one error beat. After an error the block stays silent until reset; bytes
// are still accepted and dropped.
// Throughput is one byte per cycle while the queue has room. The parse state is
// updated in the cycle the byte is taken, the result enters a QUEUE_DEPTH entry
// queue at that same edge, and the output register loads it from the queue head
// once the register is empty or its beat is taken.
// When the receiver stalls, results collect in the queue; s_tready drops
// only once the queue is full. Reset clears the parse state, the position,
// the buffer size register and all pending results.
// ----------------------------------------------------------------------------
module der_tlv_header_parser #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: buffer size in bytes.
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data,
	// Slave side: tdata = data_byte[7:0].
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,
	// Master side: tdata = tag_class[1:0], is_constructed[2], tag_number[7:3],
	// content_length[39:8], header_length[42:40], element_start[74:43],
	// content_byte[82:75], error_code[85:83], zeros[87:86].
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,
	// tuser = kind[1:0].
	output logic [1:0]   m_tuser,
	// tlast = last.
	output logic         m_tlast
);

	logic            push;
	dtlv_pkg::rec_t  push_rec;
	logic            q_full;
	logic            pop;
	logic            head_valid;
	dtlv_pkg::rec_t  head_rec;

	// Front end: parse state and result classification.
	dtlv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.byte_valid  (s_tvalid),
		.byte_data   (s_tdata),
		.byte_ready  (s_tready),
		.q_full      (q_full),
		.push        (push),
		.rec         (push_rec)
	);

	// Queue decouples parsing from a stalled receiver.
	dtlv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	// Back end: field expansion and output register.
	dtlv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

>>> design/dtlv_front.sv
// ----------------------------------------------------------------------------
// DER TLV parser front end
// Accepts DER bytes, tracks the element walk and builds one result record
// for every byte that causes a result.
// ----------------------------------------------------------------------------
module dtlv_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               byte_valid,
	input  logic [7:0]         byte_data,
	output logic               byte_ready,
	input  logic               q_full,
	output logic               push,
	output dtlv_pkg::rec_t     rec
);

	logic [31:0]       buf_len_q;
	dtlv_pkg::phase_t  phase_q, phase_n;
	logic [31:0]       pos_q, pos_n;
	logic [31:0]       start_q, start_n;
	logic [7:0]        ident_q, ident_n;
	logic [31:0]       acc_q, acc_n;
	logic [2:0]        left_q, left_n;
	logic [31:0]       cont_q, cont_n;

	logic              take;
	logic              past_end;
	logic [31:0]       pos_inc;
	logic [31:0]       acc_shift;
	logic [2:0]        left_dec;
	logic [6:0]        count;
	logic [31:0]       fin_len;
	logic [31:0]       room;
	logic              overflow;
	logic              id_trunc;
	logic              len_trunc;
	logic [31:0]       cont_dec;

	assign byte_ready = !q_full;
	assign take       = byte_valid && !q_full;

	assign past_end  = pos_q >= buf_len_q;
	assign pos_inc   = pos_q + 32'd1;
	assign acc_shift = {acc_q[23:0], byte_data};
	assign left_dec  = left_q - 3'd1;
	assign count     = byte_data[6:0] & dtlv_pkg::LEN_COUNT_MASK;
	assign fin_len   = (phase_q == dtlv_pkg::PH_LEN_FIRST) ? {24'd0, byte_data} : acc_shift;
	// Only used while pos_q < buf_len_q, so this cannot wrap.
	assign room      = buf_len_q - pos_inc;
	assign overflow  = fin_len > room;
	assign id_trunc  = ({1'b0, pos_q} + 33'd1) >= {1'b0, buf_len_q};
	assign len_trunc = ({1'b0, pos_q} + 33'd1 + {26'd0, count}) > {1'b0, buf_len_q};
	assign cont_dec  = (cont_q != 32'd0) ? (cont_q - 32'd1) : 32'd0;

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		start_n = start_q;
		ident_n = ident_q;
		acc_n   = acc_q;
		left_n  = left_q;
		cont_n  = cont_q;
		push    = 1'b0;
		rec     = '0;

		if (take && phase_q != dtlv_pkg::PH_ERROR) begin
			if (past_end) begin
				push       = 1'b1;
				rec.kind   = dtlv_pkg::KIND_ERROR;
				rec.code   = dtlv_pkg::ERR_PAST_END;
				rec.start  = (phase_q == dtlv_pkg::PH_IDENT) ? pos_q : start_q;
				phase_n    = dtlv_pkg::PH_ERROR;
			end else begin
				pos_n = pos_inc;
				// Descriptor fields, used when a header completes.
				rec.byte_val = ident_q;
				rec.length   = fin_len;
				rec.hdr_len  = pos_q[2:0] - start_q[2:0] + 3'd1;
				rec.start    = start_q;
				rec.last     = (fin_len == 32'd0);
				case (phase_q)
					dtlv_pkg::PH_IDENT: begin
						start_n   = pos_q;
						ident_n   = byte_data;
						rec.start = pos_q;
						rec.kind  = dtlv_pkg::KIND_ERROR;
						rec.last  = 1'b0;
						if (byte_data[4:0] == dtlv_pkg::ID_HIGH_TAG) begin
							push     = 1'b1;
							rec.code = dtlv_pkg::ERR_HIGH_TAG;
							phase_n  = dtlv_pkg::PH_ERROR;
						end else if (id_trunc) begin
							push     = 1'b1;
							rec.code = dtlv_pkg::ERR_TRUNCATED;
							phase_n  = dtlv_pkg::PH_ERROR;
						end else begin
							phase_n = dtlv_pkg::PH_LEN_FIRST;
						end
					end
					dtlv_pkg::PH_LEN_FIRST: begin
						push = 1'b1;
						if ((byte_data & dtlv_pkg::LEN_LONG_FORM) == 8'd0) begin
							if (overflow) begin
								rec.kind = dtlv_pkg::KIND_ERROR;
								rec.code = dtlv_pkg::ERR_OVERFLOW;
								phase_n  = dtlv_pkg::PH_ERROR;
							end else begin
								rec.kind = dtlv_pkg::KIND_DESC;
								cont_n   = fin_len;
								phase_n  = (fin_len == 32'd0) ? dtlv_pkg::PH_IDENT
								                               : dtlv_pkg::PH_CONTENT;
							end
						end else if (count == 7'd0 ||
						             count > 7'(dtlv_pkg::MAX_LENGTH_BYTES)) begin
							rec.kind = dtlv_pkg::KIND_ERROR;
							rec.code = dtlv_pkg::ERR_BAD_COUNT;
							phase_n  = dtlv_pkg::PH_ERROR;
						end else if (len_trunc) begin
							rec.kind = dtlv_pkg::KIND_ERROR;
							rec.code = dtlv_pkg::ERR_TRUNCATED;
							phase_n  = dtlv_pkg::PH_ERROR;
						end else begin
							push    = 1'b0;
							acc_n   = 32'd0;
							left_n  = count[2:0];
							phase_n = dtlv_pkg::PH_LEN_LONG;
						end
					end
					dtlv_pkg::PH_LEN_LONG: begin
						if (acc_q == 32'd0 && byte_data == 8'd0) begin
							push     = 1'b1;
							rec.kind = dtlv_pkg::KIND_ERROR;
							rec.code = dtlv_pkg::ERR_LEAD_ZERO;
							phase_n  = dtlv_pkg::PH_ERROR;
						end else begin
							acc_n  = acc_shift;
							left_n = left_dec;
							if (left_dec == 3'd0) begin
								push = 1'b1;
								if (acc_shift < 32'h80) begin
									rec.kind = dtlv_pkg::KIND_ERROR;
									rec.code = dtlv_pkg::ERR_NON_MIN;
									phase_n  = dtlv_pkg::PH_ERROR;
								end else if (overflow) begin
									rec.kind = dtlv_pkg::KIND_ERROR;
									rec.code = dtlv_pkg::ERR_OVERFLOW;
									phase_n  = dtlv_pkg::PH_ERROR;
								end else begin
									rec.kind = dtlv_pkg::KIND_DESC;
									cont_n   = acc_shift;
									phase_n  = dtlv_pkg::PH_CONTENT;
								end
							end
						end
					end
					dtlv_pkg::PH_CONTENT: begin
						push         = 1'b1;
						rec.kind     = dtlv_pkg::KIND_DATA;
						rec.byte_val = byte_data;
						cont_n       = cont_dec;
						rec.last     = (cont_dec == 32'd0);
						if (cont_dec == 32'd0) begin
							phase_n = dtlv_pkg::PH_IDENT;
						end
					end
					default: begin
						phase_n = dtlv_pkg::PH_ERROR;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_len_q <= 32'd0;
			phase_q   <= dtlv_pkg::PH_IDENT;
			pos_q     <= 32'd0;
			start_q   <= 32'd0;
			ident_q   <= 8'd0;
			acc_q     <= 32'd0;
			left_q    <= 3'd0;
			cont_q    <= 32'd0;
		end else begin
			if (cfg_wr_en) begin
				buf_len_q <= cfg_wr_data;
			end
			phase_q <= phase_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			ident_q <= ident_n;
			acc_q   <= acc_n;
			left_q  <= left_n;
			cont_q  <= cont_n;
		end
	end

endmodule

>>> design/dtlv_queue.sv
// ----------------------------------------------------------------------------
// DER TLV parser result queue
// Small register FIFO of result records between the front and back ends.
// ----------------------------------------------------------------------------
module dtlv_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dtlv_pkg::rec_t  push_rec,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output dtlv_pkg::rec_t  head_rec
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dtlv_pkg::rec_t mem_q [DEPTH];
	logic [IW-1:0]  wr_ptr_q;
	logic [IW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/dtlv_back.sv
// ----------------------------------------------------------------------------
// DER TLV parser back end
// Expands result records into output fields by kind and holds them in the
// output register until the receiver takes the beat.
// ----------------------------------------------------------------------------
module dtlv_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  dtlv_pkg::rec_t                 head_rec,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dtlv_pkg::TDATA_W-1:0]   m_tdata,
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);

	logic                          out_valid_q;
	logic [dtlv_pkg::TDATA_W-1:0]  tdata_q;
	logic [1:0]                    tuser_q;
	logic                          tlast_q;
	logic                          load;
	logic [dtlv_pkg::TDATA_W-1:0]  tdata_n;
	logic                          tlast_n;

	assign load = !out_valid_q || m_tready;
	assign pop  = load && head_valid;

	// Fields that do not belong to the record's kind go out as zero.
	always_comb begin
		tdata_n = '0;
		tlast_n = 1'b0;
		case (head_rec.kind)
			dtlv_pkg::KIND_DESC: begin
				tdata_n[1:0]   = head_rec.byte_val[7:6];
				tdata_n[2]     = (head_rec.byte_val & dtlv_pkg::ID_CONSTRUCTED) != 8'd0;
				tdata_n[7:3]   = head_rec.byte_val[4:0];
				tdata_n[39:8]  = head_rec.length;
				tdata_n[42:40] = head_rec.hdr_len;
				tdata_n[74:43] = head_rec.start;
				tlast_n        = head_rec.last;
			end
			dtlv_pkg::KIND_DATA: begin
				tdata_n[82:75] = head_rec.byte_val;
				tlast_n        = head_rec.last;
			end
			dtlv_pkg::KIND_ERROR: begin
				tdata_n[74:43] = head_rec.start;
				tdata_n[85:83] = head_rec.code;
			end
			default: begin
				tdata_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tdata_q <= tdata_n;
			tuser_q <= head_rec.kind;
			tlast_q <= tlast_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// DER TLV header parser testbench
// Streams DER buffers into the parser, one byte per beat, and checks every
// result beat field by field against an in-bench model of the element walk.
// A short directed run comes first, followed by three randomized phases with
// different idle patterns. The run ends on one randomly chosen encoding fault.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Watchdog bound. The run sends about 800 bytes.
	localparam int unsigned LIMIT_CYCLES = 200_000;
	// Cycles allowed for a byte that yields no result to clear the pipeline.
	localparam int unsigned SETTLE_CYCLES = 8;
	// At least this many bytes of well-formed elements are generated per random phase.
	localparam int unsigned PHASE_BYTES = 70;

	// One result beat, unpacked into the fields of the master channel.
	typedef struct packed {
		dtlv_pkg::kind_t     kind;
		logic [1:0]          tag_class;
		logic                constructed;
		logic [4:0]          tag_num;
		logic [31:0]         content_len;
		logic [2:0]          hdr_len;
		logic [31:0]         elem_start;
		logic [7:0]          content_byte;
		logic                last;
		dtlv_pkg::err_code_t code;
	} parse_rec_t;

	// Rows of the directed stimulus list.
	typedef enum {
		ROW_CFG,   // write the buffer size
		ROW_FIT,   // write the buffer size as current offset plus val
		ROW_BYTE,  // one byte beat
		ROW_FILL   // val random content bytes
	} row_kind_t;

	typedef struct {
		row_kind_t  op;
		logic [31:0] val;
		bit          pinned;
		parse_rec_t  pin;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// Model of the element walk: its own copy of the buffer size and state.
	logic [31:0]       walk_buf_len = '0;
	dtlv_pkg::phase_t  walk_phase = dtlv_pkg::PH_IDENT;
	logic [31:0]       walk_pos = '0;
	logic [31:0]       walk_start = '0;
	logic [7:0]        walk_id = '0;
	logic [31:0]       walk_acc = '0;
	logic [2:0]        walk_nleft = '0;
	logic [31:0]       walk_left = '0;

	// Results the parser still owes, oldest first.
	parse_rec_t  pending_results[$];
	dir_row_t    dir_rows[$];

	// A pinned byte carries a hand-written expectation that replaces the
	// model's output for that beat.
	bit          pin_on = 1'b0;
	parse_rec_t  pin_rec = '0;

	int unsigned fail_cnt = 0;
	int unsigned gap_pct = 18;
	int unsigned stall_pct = 78;

	der_tlv_header_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random; the stall rate changes per phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic parse_rec_t desc_rec(input logic [1:0] cls, input logic cons,
			input logic [4:0] num, input logic [31:0] len, input logic [2:0] hl,
			input logic [31:0] at);
		parse_rec_t r;
		r = '0;
		r.kind = dtlv_pkg::KIND_DESC;
		r.tag_class = cls;
		r.constructed = cons;
		r.tag_num = num;
		r.content_len = len;
		r.hdr_len = hl;
		r.elem_start = at;
		r.last = (len == 32'd0);
		return r;
	endfunction

	function automatic parse_rec_t data_rec(input logic [7:0] b, input logic lst);
		parse_rec_t r;
		r = '0;
		r.kind = dtlv_pkg::KIND_DATA;
		r.content_byte = b;
		r.last = lst;
		return r;
	endfunction

	// Any error parks the walk for good, since reset is never applied again.
	function automatic bit raise_err(input dtlv_pkg::err_code_t code,
			input logic [31:0] at, output parse_rec_t r);
		r = '0;
		r.kind = dtlv_pkg::KIND_ERROR;
		r.elem_start = at;
		r.code = code;
		walk_phase = dtlv_pkg::PH_ERROR;
		return 1'b1;
	endfunction

	// Header complete at offset p: the content must fit in what is left of
	// the buffer after the header, otherwise the element overflows.
	function automatic bit close_header(input logic [31:0] len, input logic [31:0] p,
			output parse_rec_t r);
		logic [32:0] after_hdr;
		logic [32:0] room;
		after_hdr = 33'(p) + 33'd1;
		room = (33'(walk_buf_len) > after_hdr) ? 33'(walk_buf_len) - after_hdr : 33'd0;
		if (33'(len) > room)
			return raise_err(dtlv_pkg::ERR_OVERFLOW, walk_start, r);
		r = desc_rec(walk_id[7:6], walk_id[5], walk_id[4:0], len,
			3'(p - walk_start + 32'd1), walk_start);
		walk_left = len;
		walk_phase = (len == 32'd0) ? dtlv_pkg::PH_IDENT : dtlv_pkg::PH_CONTENT;
		return 1'b1;
	endfunction

	// Advances the walk by one byte; returns 1 when the byte yields a result.
	function automatic bit parse_byte(input logic [7:0] b, output parse_rec_t r);
		logic [31:0] p;
		logic [6:0]  cnt;
		r = '0;
		p = walk_pos;
		if (walk_phase == dtlv_pkg::PH_ERROR)
			return 1'b0;
		// A byte beyond the buffer end is a fault in every phase.
		if (p >= walk_buf_len)
			return raise_err(dtlv_pkg::ERR_PAST_END,
				(walk_phase == dtlv_pkg::PH_IDENT) ? p : walk_start, r);
		walk_pos = p + 32'd1;
		case (walk_phase)
			dtlv_pkg::PH_IDENT: begin
				walk_start = p;
				walk_id = b;
				if (b[4:0] == dtlv_pkg::ID_HIGH_TAG)
					return raise_err(dtlv_pkg::ERR_HIGH_TAG, p, r);
				// An identifier with no room left for a length byte.
				if (33'(p) + 33'd1 >= 33'(walk_buf_len))
					return raise_err(dtlv_pkg::ERR_TRUNCATED, p, r);
				walk_phase = dtlv_pkg::PH_LEN_FIRST;
				return 1'b0;
			end
			dtlv_pkg::PH_LEN_FIRST: begin
				if (b < dtlv_pkg::LEN_LONG_FORM)
					return close_header({24'd0, b}, p, r);
				cnt = b[6:0] & dtlv_pkg::LEN_COUNT_MASK;
				// The count is vetted before the truncation check.
				if (cnt == 7'd0 || cnt > 7'(dtlv_pkg::MAX_LENGTH_BYTES))
					return raise_err(dtlv_pkg::ERR_BAD_COUNT, walk_start, r);
				if (33'(p) + 33'd1 + 33'(cnt) > 33'(walk_buf_len))
					return raise_err(dtlv_pkg::ERR_TRUNCATED, walk_start, r);
				walk_acc = '0;
				walk_nleft = cnt[2:0];
				walk_phase = dtlv_pkg::PH_LEN_LONG;
				return 1'b0;
			end
			dtlv_pkg::PH_LEN_LONG: begin
				// The accumulator is still zero only on the first length byte.
				if (walk_acc == 32'd0 && b == 8'd0)
					return raise_err(dtlv_pkg::ERR_LEAD_ZERO, walk_start, r);
				walk_acc = {walk_acc[23:0], b};
				walk_nleft = walk_nleft - 3'd1;
				if (walk_nleft != 3'd0)
					return 1'b0;
				if (walk_acc < 32'h80)
					return raise_err(dtlv_pkg::ERR_NON_MIN, walk_start, r);
				return close_header(walk_acc, p, r);
			end
			dtlv_pkg::PH_CONTENT: begin
				r = data_rec(b, 1'b0);
				if (walk_left != 32'd0)
					walk_left = walk_left - 32'd1;
				if (walk_left == 32'd0) begin
					r.last = 1'b1;
					walk_phase = dtlv_pkg::PH_IDENT;
				end
				return 1'b1;
			end
			default: begin
				walk_phase = dtlv_pkg::PH_ERROR;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic cmp_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_cnt++;
		end
	endtask

	// Monitor: result beats are checked before the byte beat of the same edge
	// is modeled, so a stray result can never consume a fresh expectation.
	always @(posedge clk) begin
		parse_rec_t got;
		parse_rec_t want;
		parse_rec_t pred;
		bit         has;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.kind = dtlv_pkg::kind_t'(m_tuser);
				got.tag_class = m_tdata[1:0];
				got.constructed = m_tdata[2];
				got.tag_num = m_tdata[7:3];
				got.content_len = m_tdata[39:8];
				got.hdr_len = m_tdata[42:40];
				got.elem_start = m_tdata[74:43];
				got.content_byte = m_tdata[82:75];
				got.code = dtlv_pkg::err_code_t'(m_tdata[85:83]);
				got.last = m_tlast;
				if (pending_results.size() == 0) begin
					$error("result beat with no result pending: kind 0x%0h", m_tuser);
					fail_cnt++;
				end else begin
					want = pending_results.pop_front();
					cmp_field("kind", 32'(want.kind), 32'(got.kind));
					cmp_field("tag_class", 32'(want.tag_class), 32'(got.tag_class));
					cmp_field("is_constructed", 32'(want.constructed),
						32'(got.constructed));
					cmp_field("tag_number", 32'(want.tag_num), 32'(got.tag_num));
					cmp_field("content_length", want.content_len, got.content_len);
					cmp_field("header_length", 32'(want.hdr_len), 32'(got.hdr_len));
					cmp_field("element_start", want.elem_start, got.elem_start);
					cmp_field("content_byte", 32'(want.content_byte),
						32'(got.content_byte));
					cmp_field("last", 32'(want.last), 32'(got.last));
					cmp_field("error_code", 32'(want.code), 32'(got.code));
					cmp_field("tdata padding", 32'd0, 32'(m_tdata[87:86]));
				end
			end
			if (cfg_wr_en)
				walk_buf_len = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				has = parse_byte(s_tdata, pred);
				if (pin_on) begin
					has = 1'b1;
					pred = pin_rec;
				end
				if (has)
					pending_results.push_back(pred);
			end
		end
	end

	// Sends one byte beat after a random number of idle cycles and returns at
	// the edge that accepts it. The next call or a drain always drives the
	// following falling edge, so a beat is never taken twice.
	task automatic send_byte(input logic [7:0] b, input bit pin, input parse_rec_t pr);
		while ($urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		pin_on = pin;
		pin_rec = pr;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Holds the sender off until every pending result has arrived, then lets
	// the pipeline settle in case the last byte produced nothing.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_buffer(input logic [31:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic dir_row_t plain(input row_kind_t op, input logic [31:0] v);
		dir_row_t d;
		d.op = op;
		d.val = v;
		d.pinned = 1'b0;
		d.pin = '0;
		return d;
	endfunction

	function automatic dir_row_t pinned(input logic [7:0] b, input parse_rec_t e);
		dir_row_t d;
		d.op = ROW_BYTE;
		d.val = {24'd0, b};
		d.pinned = 1'b1;
		d.pin = e;
		return d;
	endfunction

	// Watchdog: the run fails if it has not wrapped up by the cycle limit.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [7:0]  stream[$];
		logic [7:0]  id;
		logic [31:0] len;
		logic [31:0] base;
		logic [31:0] limit_v;
		logic [31:0] huge;
		int unsigned sel;
		int unsigned cnt;
		int unsigned pick;

		// Directed list. Offsets are fixed while the walk runs with the
		// largest buffer, so early descriptors are written out by hand.
		dir_rows.push_back(plain(ROW_CFG, 32'hFFFF_FFFF));
		// Universal primitive tag 0 with an empty body: a last-marked descriptor.
		dir_rows.push_back(plain(ROW_BYTE, 32'h00));
		dir_rows.push_back(pinned(8'h00, desc_rec(2'd0, 1'b0, 5'd0, 32'd0, 3'd2, 32'd0)));
		// Private constructed tag 30, two content bytes at both extremes.
		dir_rows.push_back(plain(ROW_BYTE, 32'hFE));
		dir_rows.push_back(pinned(8'h02, desc_rec(2'd3, 1'b1, 5'd30, 32'd2, 3'd2, 32'd2)));
		dir_rows.push_back(pinned(8'hFF, data_rec(8'hFF, 1'b0)));
		dir_rows.push_back(pinned(8'h00, data_rec(8'h00, 1'b1)));
		// Smallest one-byte long form.
		dir_rows.push_back(plain(ROW_BYTE, 32'h41));
		dir_rows.push_back(plain(ROW_BYTE, 32'h81));
		dir_rows.push_back(pinned(8'h80, desc_rec(2'd1, 1'b0, 5'd1, 32'd128, 3'd3, 32'd6)));
		dir_rows.push_back(plain(ROW_FILL, 32'd128));
		// Smallest two-byte long form, second length byte zero.
		dir_rows.push_back(plain(ROW_BYTE, 32'h9E));
		dir_rows.push_back(plain(ROW_BYTE, 32'h82));
		dir_rows.push_back(plain(ROW_BYTE, 32'h01));
		dir_rows.push_back(pinned(8'h00, desc_rec(2'd2, 1'b0, 5'd30, 32'd256, 3'd4, 32'd137)));
		dir_rows.push_back(plain(ROW_FILL, 32'd256));
		// Largest short form.
		dir_rows.push_back(plain(ROW_BYTE, 32'hDE));
		dir_rows.push_back(plain(ROW_BYTE, 32'h7F));
		dir_rows.push_back(plain(ROW_FILL, 32'd127));
		// One element whose content ends exactly at the buffer end.
		dir_rows.push_back(plain(ROW_FIT, 32'd5));
		dir_rows.push_back(plain(ROW_BYTE, 32'h04));
		dir_rows.push_back(plain(ROW_BYTE, 32'h03));
		dir_rows.push_back(plain(ROW_FILL, 32'd3));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			case (dir_rows[i].op)
				ROW_CFG: set_buffer(dir_rows[i].val);
				ROW_FIT: begin
					drain();
					set_buffer(walk_pos + dir_rows[i].val);
				end
				ROW_BYTE: send_byte(dir_rows[i].val[7:0], dir_rows[i].pinned, dir_rows[i].pin);
				default: begin
					repeat (dir_rows[i].val)
						send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
				end
			endcase
		end

		// Random phases of well-formed element runs. Any malformed byte would
		// end the walk for the rest of the run, so faults wait for the end.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					gap_pct = 18;
					stall_pct = 78;
				end
				1: begin
					gap_pct = 78;
					stall_pct = 18;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			stream.delete();
			while (stream.size() < PHASE_BYTES) begin
				id = 8'($urandom_range(0, 255));
				if (id[4:0] == dtlv_pkg::ID_HIGH_TAG)
					id[4:0] = 5'($urandom_range(0, 30));
				sel = $urandom_range(0, 99);
				if (sel < 75)
					len = $urandom_range(0, 4);
				else if (sel < 96)
					len = $urandom_range(5, 30);
				else
					len = $urandom_range(128, 140);
				stream.push_back(id);
				if (len < 32'd128) begin
					stream.push_back(len[7:0]);
				end else if (len < 32'd256) begin
					stream.push_back(8'h81);
					stream.push_back(len[7:0]);
				end else begin
					stream.push_back(8'h82);
					stream.push_back(len[15:8]);
					stream.push_back(len[7:0]);
				end
				repeat (len)
					stream.push_back(8'($urandom_range(0, 255)));
			end
			// First phase fills the buffer exactly, the second leaves up to 1000 bytes
			// of slack, the last uses the largest size.
			drain();
			base = walk_pos;
			case (ph)
				0: limit_v = base + stream.size();
				1: limit_v = base + stream.size() + $urandom_range(0, 1000);
				default: limit_v = 32'hFFFF_FFFF;
			endcase
			set_buffer(limit_v);
			foreach (stream[i]) begin
				if ($urandom_range(0, 99) == 0)
					drain();
				send_byte(stream[i], 1'b0, '0);
			end
		end

		// Closing fault, one kind per run, chosen at random.
		drain();
		base = walk_pos;
		id = 8'($urandom_range(0, 255));
		if (id[4:0] == dtlv_pkg::ID_HIGH_TAG)
			id[4:0] = 5'd0;
		limit_v = 32'hFFFF_FFFF;
		pick = $urandom_range(0, 9);
		case (pick)
			// High tag number form.
			0: stream = '{id | 8'h1F};
			// Identifier is the last byte of the buffer.
			1: begin
				limit_v = base + 32'd1;
				stream = '{id};
			end
			// Indefinite length.
			2: stream = '{id, dtlv_pkg::LEN_LONG_FORM};
			// Length-of-length above the supported maximum.
			3: stream = '{id, dtlv_pkg::LEN_LONG_FORM | 8'($urandom_range(5, 127))};
			// Long form whose length bytes run past the buffer end.
			4: begin
				cnt = $urandom_range(1, 4);
				limit_v = base + 32'd2 + $urandom_range(0, cnt - 1);
				stream = '{id, dtlv_pkg::LEN_LONG_FORM | 8'(cnt)};
			end
			// Long form with a leading zero length byte.
			5: begin
				cnt = $urandom_range(1, 4);
				stream = '{id, dtlv_pkg::LEN_LONG_FORM | 8'(cnt), 8'h00};
			end
			// Long form for a value that fits the short form.
			6: stream = '{id, 8'h81, 8'($urandom_range(1, 127))};
			// Content larger than the rest of the buffer.
			7: begin
				if ($urandom_range(0, 1) == 0) begin
					len = $urandom_range(1, 127);
					limit_v = base + 32'd2 + $urandom_range(0, len - 1);
					stream = '{id, len[7:0]};
				end else begin
					// The header fits, but a length of at least 0xFF000000
					// never fits in what is left.
					limit_v = base + 32'd6 + 32'($urandom_range(0, 1000));
					stream = '{id, 8'h84, 8'hFF, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
				end
			end
			// Byte arriving between elements with the buffer used up.
			8: begin
				limit_v = base;
				stream = '{8'($urandom_range(0, 255))};
			end
			// Four-byte length, then the buffer is cut short inside the content.
			default: begin
				huge = {8'($urandom_range(1, 254)), 24'($urandom_range(0, 32'hFF_FFFF))};
				stream = '{id, 8'h84, huge[31:24], huge[23:16], huge[15:8], huge[7:0]};
				repeat ($urandom_range(1, 40))
					stream.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		set_buffer(limit_v);
		foreach (stream[i])
			send_byte(stream[i], 1'b0, '0);
		if (pick == 9) begin
			drain();
			set_buffer(walk_pos);
			send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		end
		// The parser must stay silent after its error beat.
		repeat (16)
			send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		drain();

		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
